// ===== src/tlape_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlape_pkg
// shared constants, angle wrap and arctangent table for the arm error block
// ----------------------------------------------------------------------------
package tlape_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int ZW = 34;

  localparam logic REG_FIRST_LINK  = 1'b0;
  localparam logic REG_SECOND_LINK = 1'b1;

  localparam logic [14:0] FIRST_LINK_RESET  = 15'd7373;
  localparam logic [14:0] SECOND_LINK_RESET = 15'd4096;

  localparam logic signed [19:0] PI_Q12       = 20'sd12868;
  localparam logic signed [19:0] TWO_PI_Q12   = 20'sd25736;
  localparam logic signed [19:0] THREE_PI_Q12 = 20'sd38604;
  localparam logic signed [19:0] FOUR_PI_Q12  = 20'sd51472;
  localparam logic signed [19:0] FIVE_PI_Q12  = 20'sd64340;
  localparam logic signed [19:0] SIX_PI_Q12   = 20'sd77208;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  // wrap to [-pi, pi) in q4.12, input within seven half turns of zero
  function automatic logic signed [15:0] wrap_angle(input logic signed [19:0] v);
    logic signed [19:0] r;
    if (v >= FIVE_PI_Q12) begin
      r = v - SIX_PI_Q12;
    end else if (v >= THREE_PI_Q12) begin
      r = v - FOUR_PI_Q12;
    end else if (v >= PI_Q12) begin
      r = v - TWO_PI_Q12;
    end else if (v < -FIVE_PI_Q12) begin
      r = v + SIX_PI_Q12;
    end else if (v < -THREE_PI_Q12) begin
      r = v + FOUR_PI_Q12;
    end else if (v < -PI_Q12) begin
      r = v + TWO_PI_Q12;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/tlape_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlape_cordic
// pipelined rotation cordic: one fold stage, then one register stage per step
// ----------------------------------------------------------------------------
module tlape_cordic
  import tlape_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic signed [15:0] angle,
  output logic signed [ZW-1:0]    cosine,
  output logic signed [ZW-1:0]    sine
);

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic signed [ZW-1:0] x_q [0:NS];
  logic signed [ZW-1:0] y_q [0:NS];
  logic signed [ZW-1:0] z_q [0:NS];
  logic                 neg_q [0:NS];

  logic signed [ZW-1:0] z_in;

  assign z_in = {{(ZW-16){angle[15]}}, angle} <<< 18;

  always_ff @(posedge clk) begin
    x_q[0] <= GAIN_Q30;
    y_q[0] <= '0;
    if (z_in > HALF_PI_Q30) begin
      z_q[0]   <= z_in - PI_Q30;
      neg_q[0] <= 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z_q[0]   <= z_in + PI_Q30;
      neg_q[0] <= 1'b1;
    end else begin
      z_q[0]   <= z_in;
      neg_q[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk) begin
      neg_q[i+1] <= neg_q[i];
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN_Q30[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN_Q30[i];
      end
    end
  end

  assign cosine = neg_q[NS] ? -x_q[NS] : x_q[NS];
  assign sine   = neg_q[NS] ? -y_q[NS] : y_q[NS];

endmodule
`default_nettype wire

// ===== src/two_link_arm_position_error.sv =====
`timescale 1ns / 1ps
`default_nettype none
// throughput: one request per clock outside reset, set by the fully pipelined cordic stages
// busy is high only during reset; the receiver cannot stall
// reset clears valid bits and loads link lengths 7373 and 4096 (q4.12)
// ----------------------------------------------------------------------------
// two_link_arm_position_error
// squared distance between two-link arm tip and a measured point, q8.24
// ----------------------------------------------------------------------------
module two_link_arm_position_error
  import tlape_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic signed [15:0] joint_angle_one,
  input  wire logic signed [15:0] joint_angle_two,
  input  wire logic signed [15:0] angle_offset_one,
  input  wire logic signed [15:0] angle_offset_two,
  input  wire logic signed [15:0] measured_x,
  input  wire logic signed [15:0] measured_y,
  output logic                    done,
  output logic [31:0]             squared_error,
  output logic                    error_saturated
);

  localparam int NS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int CD  = NS + 1;
  localparam int LAT = NS + 7;

  logic [14:0] first_link;
  logic [14:0] second_link;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_link  <= FIRST_LINK_RESET;
      second_link <= SECOND_LINK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_LINK:  first_link  <= cfg_data;
        REG_SECOND_LINK: second_link <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // stage 1 and 2: angle sums and wrap
  logic               v1, v2;
  logic signed [15:0] a1, a2, b2;
  logic signed [16:0] s1;
  logic signed [15:0] mx1, my1, mx2, my2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
    a1  <= wrap_angle({{4{joint_angle_one[15]}}, joint_angle_one}
                      + {{4{angle_offset_one[15]}}, angle_offset_one});
    s1  <= {joint_angle_two[15], joint_angle_two} + {angle_offset_two[15], angle_offset_two};
    mx1 <= measured_x;
    my1 <= measured_y;
    a2  <= a1;
    b2  <= wrap_angle({{4{a1[15]}}, a1} + {{3{s1[16]}}, s1});
    mx2 <= mx1;
    my2 <= my1;
  end

  logic signed [ZW-1:0] ca, sa, cb, sb;

  tlape_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_a (
    .clk(clk), .angle(a2), .cosine(ca), .sine(sa)
  );

  tlape_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_b (
    .clk(clk), .angle(b2), .cosine(cb), .sine(sb)
  );

  // side band aligned with the cordic pipelines
  logic               vd  [0:CD-1];
  logic signed [15:0] mxd [0:CD-1];
  logic signed [15:0] myd [0:CD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CD; k++) begin
        vd[k] <= 1'b0;
      end
    end else begin
      vd[0] <= v2;
      for (int k = 1; k < CD; k++) begin
        vd[k] <= vd[k-1];
      end
    end
    mxd[0] <= mx2;
    myd[0] <= my2;
    for (int k = 1; k < CD; k++) begin
      mxd[k] <= mxd[k-1];
      myd[k] <= myd[k-1];
    end
  end

  // products, errors, squares, sum
  logic               vm, ve, vs;
  logic signed [49:0] pxa, pxb, pya, pyb;
  logic signed [15:0] mxm, mym;
  logic signed [29:0] ex, ey;
  logic [59:0]        sqx, sqy;
  logic signed [15:0] l1s, l2s;
  logic signed [51:0] px, py, errx, erry;
  logic [60:0]        sum;
  logic [44:0]        q24;

  assign l1s  = {1'b0, first_link};
  assign l2s  = {1'b0, second_link};
  assign px   = {{2{pxa[49]}}, pxa} + {{2{pxb[49]}}, pxb};
  assign py   = {{2{pya[49]}}, pya} + {{2{pyb[49]}}, pyb};
  assign errx = ({{36{mxm[15]}}, mxm} <<< 30) - px + 52'sd2097152;
  assign erry = ({{36{mym[15]}}, mym} <<< 30) - py + 52'sd2097152;
  assign sum  = {1'b0, sqx} + {1'b0, sqy};
  assign q24  = 45'((sum + 61'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm   <= 1'b0;
      ve   <= 1'b0;
      vs   <= 1'b0;
      done <= 1'b0;
    end else begin
      vm   <= vd[CD-1];
      ve   <= vm;
      vs   <= ve;
      done <= vs;
    end
    pxa <= l1s * ca;
    pxb <= l2s * cb;
    pya <= l1s * sa;
    pyb <= l2s * sb;
    mxm <= mxd[CD-1];
    mym <= myd[CD-1];
    ex  <= errx[51:22];
    ey  <= erry[51:22];
    sqx <= 60'(ex * ex);
    sqy <= 60'(ey * ey);
    if (q24[44:32] != '0) begin
      squared_error   <= '1;
      error_saturated <= 1'b1;
    end else begin
      squared_error   <= q24[31:0];
      error_saturated <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LAT))
    else $error("result strobe out of step with accepted requests");

  assert property (@(posedge clk) disable iff (rst)
    (done && error_saturated) |-> (squared_error == 32'hFFFFFFFF))
    else $error("saturation flag without clamped value");

endmodule
`default_nettype wire
